>>> rtl/cell_balance_controller_unit_macros.svh
`ifndef CELL_BALANCE_CONTROLLER_UNIT_MACROS_SVH
`define CELL_BALANCE_CONTROLLER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbc: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbc: next-cycle check failed");

`endif

>>> rtl/cbc_pkg.sv
package cbc_pkg;

    localparam int OPCODE_W   = 3;
    localparam int CHIP_W     = 3;
    localparam int CELL_W     = 4;
    localparam int VOLT_W     = 16;
    localparam int TIME_W     = 32;
    localparam int PHASE_W    = 3;
    localparam int COUNT_W    = 8;
    localparam int DUTY_W     = 4;
    localparam int LIMIT_W    = VOLT_W + 1;
    localparam int PERCENT_W  = 7;
    localparam int ICS_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [PERCENT_W-1:0] PERCENT_FULL  = 7'd100;
    localparam logic [DUTY_W-1:0]    DUTY_FULL     = 4'd15;
    // 2^16 / 100 rounded up; exact for every multiple of 15 up to 1500
    localparam int                   DUTY_RECIP    = 656;
    localparam int                   DUTY_SHIFT    = 16;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

    localparam logic [VOLT_W-1:0]    THRESHOLD_RST = 16'd100;
    localparam logic [TIME_W-1:0]    PERIOD_RST    = 32'd1000;
    localparam logic [ICS_W-1:0]     ICS_RST       = 4'd8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE_CELL   = 3'd0,
        OP_WRITE_LOWEST = 3'd1,
        OP_START        = 3'd2,
        OP_TICK         = 3'd3,
        OP_READ_DUTY    = 3'd4
    } op_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 3'd0,
        PH_COMPUTE   = 3'd1,
        PH_DISCHARGE = 3'd2,
        PH_WAIT      = 3'd3,
        PH_COMPLETE  = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_PERCENT = 3'd0,
        CFG_THRESHOLD    = 3'd1,
        CFG_BLEED_PERIOD = 3'd2,
        CFG_WAIT_PERIOD  = 3'd3,
        CFG_ACTIVE_ICS   = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_DECODE,
        SQ_SCAN,
        SQ_DRAIN,
        SQ_WIPE,
        SQ_READ,
        SQ_FINISH
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctl_t;

    function automatic logic [DUTY_W-1:0] duty_from_percent(input logic [PERCENT_W-1:0] percent);
        logic [PERCENT_W-1:0] pc;
        logic [10:0]          scaled;
        logic [20:0]          product;
        logic [DUTY_W-1:0]    duty;
        pc      = (percent > PERCENT_FULL) ? PERCENT_FULL : percent;
        scaled  = 11'(pc) * 11'(DUTY_FULL);
        product = 21'(scaled) * 21'(DUTY_RECIP);
        duty    = product[DUTY_SHIFT +: DUTY_W];
        // nonzero percent never maps to zero duty
        if (pc != '0 && duty == '0)
        begin
            duty = 4'd1;
        end
        return duty;
    endfunction

endpackage

>>> rtl/cbc_cell_store.sv
module cbc_cell_store #(
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       v_we,
    input  logic [ADDR_W-1:0]          v_waddr,
    input  logic [cbc_pkg::VOLT_W-1:0] v_wdata,
    input  logic [ADDR_W-1:0]          v_raddr,
    output logic [cbc_pkg::VOLT_W-1:0] v_rdata,
    input  logic                       d_we,
    input  logic [ADDR_W-1:0]          d_waddr,
    input  logic [cbc_pkg::DUTY_W-1:0] d_wdata,
    input  logic [ADDR_W-1:0]          d_raddr,
    output logic [cbc_pkg::DUTY_W-1:0] d_rdata
);
    import cbc_pkg::*;

    logic [VOLT_W-1:0] volt_mem [DEPTH];
    logic [DUTY_W-1:0] duty_mem [DEPTH];
    logic [VOLT_W-1:0] v_rdata_reg;
    logic [DUTY_W-1:0] d_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            volt_mem[v_waddr] <= v_wdata;
        end
        v_rdata_reg <= volt_mem[v_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            duty_mem[d_waddr] <= d_wdata;
        end
        d_rdata_reg <= duty_mem[d_raddr];
    end

    assign v_rdata = v_rdata_reg;
    assign d_rdata = d_rdata_reg;

endmodule

>>> rtl/cbc_scan_unit.sv
module cbc_scan_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cbc_pkg::scan_ctl_t          ctl,
    input  logic [cbc_pkg::VOLT_W-1:0]  lowest,
    input  logic [cbc_pkg::VOLT_W-1:0]  threshold,
    input  logic [cbc_pkg::VOLT_W-1:0]  cell_voltage,
    output logic                        hit,
    output logic [cbc_pkg::COUNT_W-1:0] count_next
);
    import cbc_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] count_reg;

    always_comb
    begin
        hit = ctl.step && (LIMIT_W'(cell_voltage) > limit_reg);
        priority if (ctl.start)
        begin
            count_next = '0;
        end
        else if (hit && count_reg != COUNT_MAX)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // latch the margin once per scan
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            limit_reg <= LIMIT_W'(lowest) + LIMIT_W'(threshold);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/cell_balance_controller_unit.sv
// channel  dir  handshake             fields
// cfg      in   cfg_write             cfg_index, cfg_data
// in       in   in_valid / in_stall   opcode, chip_index, cell_index, voltage, time_now
// out      out  out_valid / out_stall phase, unbalanced_count, push_config, duties_cleared,
//                                     duty_value
// Each word passes decode and finish before the next is accepted, a duty read also a read state; a
// compute tick scans N cells (128 at defaults) then drains, one compare a cycle in the scan unit.
// A tick that ends discharge wipes all MAX_CHIPS * CELLS_PER_CHIP entries of the duty memory.
// After reset both memories are cleared, all MAX_CHIPS * CELLS_PER_CHIP entries (128 at defaults),
// with in_stall high; configuration writes are taken throughout.
// A result waits in the output register; out_stall holds the next word in its last cycle.
`include "cell_balance_controller_unit_macros.svh"

module cell_balance_controller_unit #(
    parameter int MAX_CHIPS      = 8,
    parameter int CELLS_PER_CHIP = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cbc_pkg::OPCODE_W-1:0]   opcode,
    input  logic [cbc_pkg::CHIP_W-1:0]     chip_index,
    input  logic [cbc_pkg::CELL_W-1:0]     cell_index,
    input  logic [cbc_pkg::VOLT_W-1:0]     voltage,
    input  logic [cbc_pkg::TIME_W-1:0]     time_now,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cbc_pkg::PHASE_W-1:0]    phase,
    output logic [cbc_pkg::COUNT_W-1:0]    unbalanced_count,
    output logic                           push_config,
    output logic                           duties_cleared,
    output logic [cbc_pkg::DUTY_W-1:0]     duty_value
);
    import cbc_pkg::*;

    localparam int TOTAL_CELLS = MAX_CHIPS * CELLS_PER_CHIP;
    localparam int SLOT_W      = $clog2(TOTAL_CELLS);
    localparam int IDX_W       = $clog2(TOTAL_CELLS + 1);
    localparam int CHIPN_W     = $clog2(MAX_CHIPS + 1);

    // configuration
    logic [PERCENT_W-1:0] duty_percent_reg;
    logic [VOLT_W-1:0]    threshold_reg;
    logic [TIME_W-1:0]    bleed_period_reg;
    logic [TIME_W-1:0]    wait_period_reg;
    logic [ICS_W-1:0]     active_ics_reg;

    // accepted word
    logic [OPCODE_W-1:0]  op_reg;
    logic [CHIP_W-1:0]    chip_reg;
    logic [CELL_W-1:0]    cell_reg;
    logic [VOLT_W-1:0]    volt_reg;
    logic [TIME_W-1:0]    time_reg;

    seq_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 scan_pend_reg, scan_pend_next;
    logic [SLOT_W-1:0]    scan_slot_reg, scan_slot_next;

    phase_t               phase_reg, phase_next;
    logic [TIME_W-1:0]    phase_start_reg, phase_start_next;
    logic [VOLT_W-1:0]    lowest_reg, lowest_next;
    logic [DUTY_W-1:0]    applied_duty_reg, applied_duty_next;
    logic [COUNT_W-1:0]   unbalanced_reg, unbalanced_next;

    logic                 push_reg, push_next;
    logic                 cleared_reg, cleared_next;
    logic [DUTY_W-1:0]    duty_out_reg, duty_out_next;

    logic                 out_valid_reg, out_valid_next;
    phase_t               out_phase_reg, out_phase_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                 out_push_reg, out_push_next;
    logic                 out_cleared_reg, out_cleared_next;
    logic [DUTY_W-1:0]    out_duty_reg, out_duty_next;

    logic                 accept;
    logic                 out_free;
    logic                 item_in_range;
    logic [SLOT_W-1:0]    item_slot;
    logic [SLOT_W-1:0]    idx_slot;
    logic [CHIPN_W-1:0]   scan_chips;
    logic [IDX_W-1:0]     scan_cells;
    logic                 idx_last_scan;
    logic                 idx_last_all;
    logic [TIME_W-1:0]    elapsed;

    logic                 v_we, d_we;
    logic [SLOT_W-1:0]    v_waddr, v_raddr, d_waddr, d_raddr;
    logic [VOLT_W-1:0]    v_wdata, v_rdata;
    logic [DUTY_W-1:0]    d_wdata, d_rdata;

    scan_ctl_t            scan_ctl;
    logic                 scan_hit;
    logic [COUNT_W-1:0]   scan_count_next;

    cbc_cell_store #(
        .DEPTH (TOTAL_CELLS)
    ) u_store (
        .clk     (clk),
        .v_we    (v_we),
        .v_waddr (v_waddr),
        .v_wdata (v_wdata),
        .v_raddr (v_raddr),
        .v_rdata (v_rdata),
        .d_we    (d_we),
        .d_waddr (d_waddr),
        .d_wdata (d_wdata),
        .d_raddr (d_raddr),
        .d_rdata (d_rdata)
    );

    cbc_scan_unit u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .lowest       (lowest_reg),
        .threshold    (threshold_reg),
        .cell_voltage (v_rdata),
        .hit          (scan_hit),
        .count_next   (scan_count_next)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != SQ_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign item_in_range = (32'(chip_reg) < 32'(MAX_CHIPS))
                        && (32'(cell_reg) < 32'(CELLS_PER_CHIP));
    assign item_slot     = SLOT_W'(32'(chip_reg) * 32'(CELLS_PER_CHIP) + 32'(cell_reg));
    assign idx_slot      = idx_reg[SLOT_W-1:0];
    assign elapsed       = time_reg - phase_start_reg;

    always_comb
    begin
        if (32'(active_ics_reg) > 32'(MAX_CHIPS))
        begin
            scan_chips = CHIPN_W'(MAX_CHIPS);
        end
        else
        begin
            scan_chips = CHIPN_W'(active_ics_reg);
        end
        scan_cells = IDX_W'(32'(scan_chips) * 32'(CELLS_PER_CHIP));
    end

    assign idx_last_scan = (idx_reg == scan_cells - IDX_W'(1));
    assign idx_last_all  = (idx_reg == IDX_W'(TOTAL_CELLS - 1));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_percent_reg <= '0;
            threshold_reg    <= THRESHOLD_RST;
            bleed_period_reg <= PERIOD_RST;
            wait_period_reg  <= PERIOD_RST;
            active_ics_reg   <= ICS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DUTY_PERCENT: duty_percent_reg <= cfg_data[PERCENT_W-1:0];
                CFG_THRESHOLD:    threshold_reg    <= cfg_data[VOLT_W-1:0];
                CFG_BLEED_PERIOD: bleed_period_reg <= cfg_data[TIME_W-1:0];
                CFG_WAIT_PERIOD:  wait_period_reg  <= cfg_data[TIME_W-1:0];
                CFG_ACTIVE_ICS:   active_ics_reg   <= cfg_data[ICS_W-1:0];
                default:          ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_CLEAR:
            begin
                if (idx_last_all)
                begin
                    state_next = SQ_IDLE;
                end
            end
            SQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = SQ_DECODE;
                end
            end
            SQ_DECODE:
            begin
                state_next = SQ_FINISH;
                unique case (op_t'(op_reg))
                    OP_TICK:
                    begin
                        if (phase_reg == PH_COMPUTE && scan_cells != '0)
                        begin
                            state_next = SQ_SCAN;
                        end
                        else if (phase_reg == PH_DISCHARGE && elapsed >= bleed_period_reg)
                        begin
                            state_next = SQ_WIPE;
                        end
                    end
                    OP_READ_DUTY:
                    begin
                        if (item_in_range)
                        begin
                            state_next = SQ_READ;
                        end
                    end
                    default: ;
                endcase
            end
            SQ_SCAN:
            begin
                if (idx_last_scan)
                begin
                    state_next = SQ_DRAIN;
                end
            end
            SQ_DRAIN:
            begin
                state_next = SQ_FINISH;
            end
            SQ_WIPE:
            begin
                if (idx_last_all)
                begin
                    state_next = SQ_FINISH;
                end
            end
            SQ_READ:
            begin
                state_next = SQ_FINISH;
            end
            SQ_FINISH:
            begin
                if (out_free)
                begin
                    state_next = SQ_IDLE;
                end
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        idx_next          = idx_reg;
        scan_pend_next    = 1'b0;
        scan_slot_next    = idx_slot;
        phase_next        = phase_reg;
        phase_start_next  = phase_start_reg;
        lowest_next       = lowest_reg;
        applied_duty_next = applied_duty_reg;
        unbalanced_next   = unbalanced_reg;
        push_next         = push_reg;
        cleared_next      = cleared_reg;
        duty_out_next     = duty_out_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_phase_next    = out_phase_reg;
        out_count_next    = out_count_reg;
        out_push_next     = out_push_reg;
        out_cleared_next  = out_cleared_reg;
        out_duty_next     = out_duty_reg;

        v_we    = 1'b0;
        v_waddr = item_slot;
        v_wdata = volt_reg;
        v_raddr = idx_slot;
        d_we    = 1'b0;
        d_waddr = idx_slot;
        d_wdata = '0;
        d_raddr = idx_slot;

        scan_ctl.start = 1'b0;
        scan_ctl.step  = scan_pend_reg;

        // merge the duty into a cell that sits above the margin
        if (scan_hit)
        begin
            d_we    = 1'b1;
            d_waddr = scan_slot_reg;
            d_wdata = d_rdata | applied_duty_reg;
        end

        unique case (state_reg)
            SQ_CLEAR:
            begin
                v_we     = 1'b1;
                v_waddr  = idx_slot;
                v_wdata  = '0;
                d_we     = 1'b1;
                idx_next = idx_last_all ? '0 : idx_reg + IDX_W'(1);
            end
            SQ_IDLE:
            begin
                if (accept)
                begin
                    idx_next      = '0;
                    push_next     = 1'b0;
                    cleared_next  = 1'b0;
                    duty_out_next = '0;
                end
            end
            SQ_DECODE:
            begin
                unique case (op_t'(op_reg))
                    OP_WRITE_CELL:
                    begin
                        v_we = item_in_range;
                    end
                    OP_WRITE_LOWEST:
                    begin
                        lowest_next = volt_reg;
                    end
                    OP_START:
                    begin
                        applied_duty_next = duty_from_percent(duty_percent_reg);
                        phase_next        = PH_COMPUTE;
                    end
                    OP_TICK:
                    begin
                        priority if (phase_reg == PH_COMPUTE)
                        begin
                            scan_ctl.start = 1'b1;
                            // nothing to scan: finish straight away
                            if (scan_cells == '0)
                            begin
                                unbalanced_next = '0;
                                phase_next      = PH_COMPLETE;
                            end
                        end
                        else if (phase_reg == PH_DISCHARGE)
                        begin
                            push_next = 1'b1;
                            if (elapsed >= bleed_period_reg)
                            begin
                                cleared_next     = 1'b1;
                                phase_next       = PH_WAIT;
                                phase_start_next = time_reg;
                            end
                        end
                        else if (phase_reg == PH_WAIT)
                        begin
                            push_next = 1'b1;
                            if (elapsed >= wait_period_reg)
                            begin
                                phase_next = PH_COMPUTE;
                            end
                        end
                        else
                        begin
                        end
                    end
                    OP_READ_DUTY:
                    begin
                        d_raddr = item_slot;
                    end
                    default: ;
                endcase
            end
            SQ_SCAN:
            begin
                scan_pend_next = 1'b1;
                scan_slot_next = idx_slot;
                idx_next       = idx_reg + IDX_W'(1);
            end
            SQ_DRAIN:
            begin
                unbalanced_next = scan_count_next;
                if (scan_count_next != '0)
                begin
                    phase_next       = PH_DISCHARGE;
                    phase_start_next = time_reg;
                end
                else
                begin
                    phase_next = PH_COMPLETE;
                end
            end
            SQ_WIPE:
            begin
                d_we     = 1'b1;
                d_waddr  = idx_slot;
                d_wdata  = '0;
                idx_next = idx_reg + IDX_W'(1);
            end
            SQ_READ:
            begin
                duty_out_next = d_rdata;
            end
            SQ_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_phase_next   = phase_reg;
                    out_count_next   = unbalanced_reg;
                    out_push_next    = push_reg;
                    out_cleared_next = cleared_reg;
                    out_duty_next    = duty_out_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            chip_reg <= chip_index;
            cell_reg <= cell_index;
            volt_reg <= voltage;
            time_reg <= time_now;
        end
        scan_slot_reg   <= scan_slot_next;
        push_reg        <= push_next;
        cleared_reg     <= cleared_next;
        duty_out_reg    <= duty_out_next;
        out_phase_reg   <= out_phase_next;
        out_count_reg   <= out_count_next;
        out_push_reg    <= out_push_next;
        out_cleared_reg <= out_cleared_next;
        out_duty_reg    <= out_duty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= SQ_CLEAR;
            idx_reg          <= '0;
            scan_pend_reg    <= 1'b0;
            phase_reg        <= PH_IDLE;
            phase_start_reg  <= '0;
            lowest_reg       <= '0;
            applied_duty_reg <= '0;
            unbalanced_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            scan_pend_reg    <= scan_pend_next;
            phase_reg        <= phase_next;
            phase_start_reg  <= phase_start_next;
            lowest_reg       <= lowest_next;
            applied_duty_reg <= applied_duty_next;
            unbalanced_reg   <= unbalanced_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign phase            = out_phase_reg;
    assign unbalanced_count = out_count_reg;
    assign push_config      = out_push_reg;
    assign duties_cleared   = out_cleared_reg;
    assign duty_value       = out_duty_reg;

    `CBC_ASSERT_NEXT(a_accept_decodes, clk, rst_n, accept, state_reg == SQ_DECODE)
    `CBC_ASSERT_IMPLY(a_scan_in_range, clk, rst_n, state_reg == SQ_SCAN, idx_reg < scan_cells)
    `CBC_ASSERT_IMPLY(a_clear_in_wait, clk, rst_n, out_valid && duties_cleared, push_config && phase == PH_WAIT)
    `CBC_ASSERT_NEXT(a_finish_loads, clk, rst_n, state_reg == SQ_FINISH && out_free, out_valid && state_reg == SQ_IDLE)

endmodule

>>> bench/cell_balance_controller_unit_tb.sv
`timescale 1ns / 1ps

module cell_balance_controller_unit_tb;
    import cbc_pkg::*;

    localparam int N_CHIPS        = 8;
    localparam int N_CELLS        = 16;
    localparam int N_SLOTS        = N_CHIPS * N_CELLS;
    localparam int OP_SPACE       = 1 << OPCODE_W;
    localparam int VOLT_TOP       = (1 << VOLT_W) - 1;
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTINGS_COUNT = 10;
    localparam int RANDOM_WORDS   = 1850;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 150;

    typedef struct packed {
        phase_t             stage;
        logic [COUNT_W-1:0] hot;
        logic               push;
        logic               wiped;
        logic [DUTY_W-1:0]  duty;
    } balance_result_t;

    class balance_tracker;
        logic [VOLT_W-1:0]    cell_mv [N_SLOTS];
        logic [DUTY_W-1:0]    bleed_duty [N_SLOTS];
        logic [VOLT_W-1:0]    floor_mv;
        phase_t               stage;
        logic [TIME_W-1:0]    stage_start;
        logic [DUTY_W-1:0]    start_duty;
        logic [COUNT_W-1:0]   hot_cells;
        logic [PERCENT_W-1:0] percent_reg;
        logic [VOLT_W-1:0]    margin_reg;
        logic [TIME_W-1:0]    bleed_ms;
        logic [TIME_W-1:0]    settle_ms;
        logic [ICS_W-1:0]     chips_reg;
        balance_result_t      due_results[$];
        int                   errors;
        int                   checked;
        int                   scans;
        int                   wipes;

        function new();
            foreach (cell_mv[i])
            begin
                cell_mv[i]    = '0;
                bleed_duty[i] = '0;
            end
            floor_mv    = '0;
            stage       = PH_IDLE;
            stage_start = '0;
            start_duty  = '0;
            hot_cells   = '0;
            percent_reg = '0;
            margin_reg  = THRESHOLD_RST;
            bleed_ms    = PERIOD_RST;
            settle_ms   = PERIOD_RST;
            chips_reg   = ICS_RST;
            errors      = 0;
            checked     = 0;
            scans       = 0;
            wipes       = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DUTY_PERCENT: percent_reg = val[PERCENT_W-1:0];
                CFG_THRESHOLD:    margin_reg  = val[VOLT_W-1:0];
                CFG_BLEED_PERIOD: bleed_ms    = val[TIME_W-1:0];
                CFG_WAIT_PERIOD:  settle_ms   = val[TIME_W-1:0];
                CFG_ACTIVE_ICS:   chips_reg   = val[ICS_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the balancing state by one accepted word and queue its result.
        function void note_word(logic [OPCODE_W-1:0] op, logic [CHIP_W-1:0] chip,
                                logic [CELL_W-1:0] cell_no, logic [VOLT_W-1:0] volt,
                                logic [TIME_W-1:0] now);
            balance_result_t   r;
            int                slot;
            int                pct;
            int                duty;
            int                scan;
            int                n;
            logic [LIMIT_W-1:0] limit;
            logic [TIME_W-1:0] elapsed;
            r = '0;
            // every chip and cell index the fields can carry is in range
            slot = int'(chip) * N_CELLS + int'(cell_no);
            elapsed = now - stage_start;
            case (op)
                OP_WRITE_CELL:   cell_mv[slot] = volt;
                OP_WRITE_LOWEST: floor_mv = volt;
                OP_START:
                begin
                    pct = (percent_reg > PERCENT_FULL) ? int'(PERCENT_FULL) : int'(percent_reg);
                    duty = pct * int'(DUTY_FULL) / int'(PERCENT_FULL);
                    if (pct != 0 && duty == 0)
                    begin
                        duty = 1;
                    end
                    start_duty = DUTY_W'(duty);
                    stage = PH_COMPUTE;
                end
                OP_TICK:
                begin
                    if (stage == PH_COMPUTE)
                    begin
                        scan = (int'(chips_reg) > N_CHIPS) ? N_CHIPS : int'(chips_reg);
                        limit = LIMIT_W'(floor_mv) + LIMIT_W'(margin_reg);
                        n = 0;
                        for (int s = 0; s < scan * N_CELLS; s++)
                        begin
                            if (LIMIT_W'(cell_mv[s]) > limit)
                            begin
                                bleed_duty[s] = bleed_duty[s] | start_duty;
                                n++;
                            end
                        end
                        hot_cells = (n > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
                        scans++;
                        if (n > 0)
                        begin
                            stage = PH_DISCHARGE;
                            stage_start = now;
                        end
                        else
                        begin
                            stage = PH_COMPLETE;
                        end
                    end
                    else if (stage == PH_DISCHARGE)
                    begin
                        r.push = 1'b1;
                        if (elapsed >= bleed_ms)
                        begin
                            foreach (bleed_duty[i])
                            begin
                                bleed_duty[i] = '0;
                            end
                            r.wiped = 1'b1;
                            stage = PH_WAIT;
                            stage_start = now;
                            wipes++;
                        end
                    end
                    else if (stage == PH_WAIT)
                    begin
                        r.push = 1'b1;
                        if (elapsed >= settle_ms)
                        begin
                            stage = PH_COMPUTE;
                        end
                    end
                end
                OP_READ_DUTY: r.duty = bleed_duty[slot];
                default: ;
            endcase
            r.stage = stage;
            r.hot = hot_cells;
            due_results.push_back(r);
        endfunction

        function void check_word(logic [PHASE_W-1:0] ph, logic [COUNT_W-1:0] cnt,
                                 logic psh, logic clr, logic [DUTY_W-1:0] dv);
            balance_result_t want;
            if (due_results.size() == 0)
            begin
                $error("result word arrived with nothing expected");
                errors++;
                return;
            end
            want = due_results.pop_front();
            checked++;
            if (ph !== want.stage)
            begin
                $error("phase: expected %0d, got %0d", want.stage, ph);
                errors++;
            end
            if (cnt !== want.hot)
            begin
                $error("unbalanced_count: expected %0d, got %0d", want.hot, cnt);
                errors++;
            end
            if (psh !== want.push)
            begin
                $error("push_config: expected %0d, got %0d", want.push, psh);
                errors++;
            end
            if (clr !== want.wiped)
            begin
                $error("duties_cleared: expected %0d, got %0d", want.wiped, clr);
                errors++;
            end
            if (dv !== want.duty)
            begin
                $error("duty_value: expected %0d, got %0d", want.duty, dv);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [OPCODE_W-1:0]   opcode;
    logic [CHIP_W-1:0]     chip_index;
    logic [CELL_W-1:0]     cell_index;
    logic [VOLT_W-1:0]     voltage;
    logic [TIME_W-1:0]     time_now;
    logic                  out_valid;
    logic                  out_stall;
    logic [PHASE_W-1:0]    phase;
    logic [COUNT_W-1:0]    unbalanced_count;
    logic                  push_config;
    logic                  duties_cleared;
    logic [DUTY_W-1:0]     duty_value;

    balance_tracker        tracker;
    bit                    src_jitter = 1'b1;
    bit                    sink_jitter = 1'b1;
    logic [TIME_W-1:0]     clock_ms;
    int                    words_in = 0;
    int                    quiet_cycles = 0;

    cell_balance_controller_unit #(
        .MAX_CHIPS      (N_CHIPS),
        .CELLS_PER_CHIP (N_CELLS)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .chip_index       (chip_index),
        .cell_index       (cell_index),
        .voltage          (voltage),
        .time_now         (time_now),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .phase            (phase),
        .unbalanced_count (unbalanced_count),
        .push_config      (push_config),
        .duties_cleared   (duties_cleared),
        .duty_value       (duty_value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: stall in short random bursts unless told to run clean.
    initial
    begin : sink_driver
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (!sink_jitter)
            begin
                hold = 0;
                out_stall <= 1'b0;
            end
            else if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(0, 6);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            tracker.check_word(phase, unbalanced_count, push_config, duties_cleared,
                               duty_value);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Entered and left at a falling edge; hold the word until it is taken.
    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [CHIP_W-1:0] chip,
                             input logic [CELL_W-1:0] cell_no, input logic [VOLT_W-1:0] volt,
                             input logic [TIME_W-1:0] now);
        if (src_jitter && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        opcode     <= op;
        chip_index <= chip;
        cell_index <= cell_no;
        voltage    <= volt;
        time_now   <= now;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_word(op, chip, cell_no, volt, now);
        words_in++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.due_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        tracker.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [PERCENT_W-1:0] pct,
                                  input logic [VOLT_W-1:0] margin,
                                  input logic [TIME_W-1:0] bleed,
                                  input logic [TIME_W-1:0] settle,
                                  input logic [ICS_W-1:0] chips);
        cfg_write <= 1'b1;
        put_reg(CFG_DUTY_PERCENT, CFG_DATA_W'(pct));
        put_reg(CFG_THRESHOLD, CFG_DATA_W'(margin));
        put_reg(CFG_BLEED_PERIOD, bleed);
        put_reg(CFG_WAIT_PERIOD, settle);
        put_reg(CFG_ACTIVE_ICS, CFG_DATA_W'(chips));
        cfg_write <= 1'b0;
    endtask

    task automatic random_word(output bit counted);
        int                  pick;
        int                  roll;
        int                  near_mv;
        logic [CHIP_W-1:0]   chip;
        logic [CELL_W-1:0]   cell_no;
        logic [VOLT_W-1:0]   volt;
        pick = $urandom_range(0, 99);
        chip = CHIP_W'($urandom_range(0, N_CHIPS - 1));
        cell_no = CELL_W'($urandom_range(0, N_CELLS - 1));
        volt = VOLT_W'($urandom_range(0, VOLT_TOP));
        counted = 1'b1;
        if (pick < 24)
        begin
            // mostly land right around lowest + threshold
            if ($urandom_range(0, 2) != 0)
            begin
                near_mv = int'(tracker.floor_mv) + int'(tracker.margin_reg)
                          + int'($urandom_range(0, 4)) - 2;
                near_mv = (near_mv < 0) ? 0 : (near_mv > VOLT_TOP) ? VOLT_TOP : near_mv;
                volt = VOLT_W'(near_mv);
            end
            send_word(OP_WRITE_CELL, chip, cell_no, volt, $urandom);
        end
        else if (pick < 29)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                volt = VOLT_W'($urandom_range(0, 20000));
            end
            send_word(OP_WRITE_LOWEST, chip, cell_no, volt, $urandom);
        end
        else if (pick < 37)
        begin
            send_word(OP_START, chip, cell_no, volt, $urandom);
        end
        else if (pick < 82)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 6)
            begin
                clock_ms = clock_ms + TIME_W'($urandom_range(0, 30));
            end
            else if (roll < 8 && tracker.stage == PH_DISCHARGE)
            begin
                clock_ms = tracker.stage_start + tracker.bleed_ms
                           - TIME_W'($urandom_range(0, 1));
            end
            else if (roll < 8 && tracker.stage == PH_WAIT)
            begin
                clock_ms = tracker.stage_start + tracker.settle_ms
                           - TIME_W'($urandom_range(0, 1));
            end
            else
            begin
                clock_ms = clock_ms + $urandom;
            end
            send_word(OP_TICK, chip, cell_no, volt, clock_ms);
        end
        else if (pick < 96)
        begin
            send_word(OP_READ_DUTY, chip, cell_no, volt, $urandom);
        end
        else
        begin
            counted = 1'b0;
            send_word(OPCODE_W'($urandom_range(int'(OP_READ_DUTY) + 1, OP_SPACE - 1)),
                      chip, cell_no, volt, $urandom);
        end
    endtask

    initial
    begin : stimulus
        logic [TIME_W-1:0] t0;
        int                done;
        bit                counted;
        tracker = new();
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        opcode     <= '0;
        chip_index <= '0;
        cell_index <= '0;
        voltage    <= '0;
        time_now   <= '0;
        clock_ms = $urandom;
        t0 = 32'hFFFF_FFF0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(OP_READ_DUTY, 3'd0, 4'd0, 16'd0, 32'd0);
        send_word(OP_TICK, 3'd0, 4'd0, 16'd0, 32'd5);
        send_word(OP_WRITE_CELL, 3'd0, 4'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(OP_WRITE_CELL, 3'd7, 4'd15, 16'hFFFF, 32'd0);
        // exactly at the limit, and one above it
        send_word(OP_WRITE_CELL, 3'd7, 4'd14, THRESHOLD_RST, 32'd0);
        send_word(OP_WRITE_CELL, 3'd7, 4'd13, THRESHOLD_RST + 16'd1, 32'd0);
        send_word(OP_WRITE_LOWEST, 3'd7, 4'd15, 16'd0, 32'd0);
        for (int op = int'(OP_READ_DUTY) + 1; op < OP_SPACE; op++)
        begin
            send_word(OPCODE_W'(op), 3'd7, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
        end
        wait_drained();
        // percent above 100 clamps to full duty
        apply_settings(7'd127, THRESHOLD_RST, PERIOD_RST, PERIOD_RST, ICS_RST);
        send_word(OP_START, 3'd0, 4'd0, 16'd0, 32'd0);
        send_word(OP_TICK, 3'd0, 4'd0, 16'd0, t0);
        send_word(OP_READ_DUTY, 3'd7, 4'd15, 16'd0, 32'd0);
        send_word(OP_READ_DUTY, 3'd7, 4'd14, 16'd0, 32'd0);
        // restart mid-discharge, then let time wrap through both periods
        send_word(OP_START, 3'd0, 4'd0, 16'd0, 32'd0);
        send_word(OP_TICK, 3'd0, 4'd0, 16'd0, t0 + 32'd1);
        send_word(OP_TICK, 3'd0, 4'd0, 16'd0, t0 + 32'd1000);
        send_word(OP_TICK, 3'd0, 4'd0, 16'd0, t0 + 32'd1001);
        send_word(OP_READ_DUTY, 3'd0, 4'd0, 16'd0, 32'd0);
        send_word(OP_TICK, 3'd0, 4'd0, 16'd0, t0 + 32'd2000);
        send_word(OP_TICK, 3'd0, 4'd0, 16'd0, t0 + 32'd2001);
        send_word(OP_TICK, 3'd0, 4'd0, 16'd0, t0 + 32'd2002);
        wait_drained();
        // small percent rounds up to duty 1; no chips scanned goes to complete
        apply_settings(7'd6, THRESHOLD_RST, PERIOD_RST, PERIOD_RST, 4'd0);
        send_word(OP_START, 3'd0, 4'd0, 16'd0, 32'd0);
        send_word(OP_TICK, 3'd0, 4'd0, 16'd0, 32'd7);
        send_word(OP_TICK, 3'd0, 4'd0, 16'd0, 32'd8);

        for (int k = 0; k < SETTINGS_COUNT; k++)
        begin
            wait_drained();
            case (k)
                0: apply_settings(7'd0, 16'd0, 32'd0, 32'd0, 4'd1);
                1: apply_settings(PERCENT_FULL, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8);
                2: apply_settings(7'd127, 16'd1, 32'd1, 32'd1, 4'd15);
                default:
                    apply_settings(PERCENT_W'($urandom_range(0, 127)),
                                   ($urandom_range(0, 2) == 0) ? VOLT_W'($urandom)
                                                               : VOLT_W'($urandom_range(0, 400)),
                                   ($urandom_range(0, 3) == 0) ? $urandom
                                                               : TIME_W'($urandom_range(0, 60)),
                                   ($urandom_range(0, 3) == 0) ? $urandom
                                                               : TIME_W'($urandom_range(0, 60)),
                                   ICS_W'($urandom_range(0, 15)));
            endcase
            if (k == SETTINGS_COUNT - 1)
            begin
                src_jitter  = 1'b0;
                sink_jitter = 1'b0;
            end
            done = 0;
            while (done < RANDOM_WORDS / SETTINGS_COUNT)
            begin
                random_word(counted);
                if (counted)
                begin
                    done++;
                end
                // hold off once until the block has caught up completely
                if (k == 3 && done == RANDOM_WORDS / SETTINGS_COUNT / 2 && counted)
                begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Run: %0d words in, %0d results checked, %0d scans, %0d discharge ends,",
                 words_in, tracker.checked, tracker.scans, tracker.wipes);
        $display("     %0d register settings, random idle and stall bursts on both sides",
                 SETTINGS_COUNT + 2);
        if (tracker.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> cell_balance_controller_unit.f
+incdir+rtl
rtl/cbc_pkg.sv
rtl/cbc_cell_store.sv
rtl/cbc_scan_unit.sv
rtl/cell_balance_controller_unit.sv
bench/cell_balance_controller_unit_tb.sv
